FILE: rtl/lqs_pkg.sv
// Package for the linear queue with search: payload structs, opcodes,
// status codes and sequencer states. No dependencies.
`timescale 1ns / 1ps

package lqs_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int WORD_W    = 32;
  localparam int SLOT_W    = 6;

  typedef enum logic [1:0] {
    OP_ENQ  = 2'd0,
    OP_DEQ  = 2'd1,
    OP_TRAV = 2'd2,
    OP_SRCH = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_OVERFLOW  = 3'd1,
    ST_REMOVED   = 3'd2,
    ST_UNDERFLOW = 3'd3,
    ST_EMPTY     = 3'd4,
    ST_ELEMENT   = 3'd5,
    ST_NOTFOUND  = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECIDE,
    S_WALK
  } fsm_t;

  typedef struct packed {
    op_t                       opcode;
    logic signed [WORD_W-1:0]  data_value;
  } in_item_t;

  typedef struct packed {
    status_t                   status;
    logic signed [WORD_W-1:0]  word;
    logic [SLOT_W-1:0]         slot_index;
    logic                      last;
    logic                      full_flag;
    logic                      empty_flag;
  } out_item_t;

endpackage

FILE: rtl/lqs_mem.sv
// Slot store of the queue: one write port and one registered read port.
// Uses lqs_pkg for the word width.
`timescale 1ns / 1ps

module lqs_mem #(
  parameter int DEPTH = lqs_pkg::DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic signed [lqs_pkg::WORD_W-1:0] wdata,
  input  logic                             re,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic signed [lqs_pkg::WORD_W-1:0] rdata
);

  logic signed [lqs_pkg::WORD_W-1:0] mem [DEPTH];
  logic signed [lqs_pkg::WORD_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/lqs_ctrl.sv
// Sequencer of the queue: head/tail pointers, the slot walk with its
// compare unit, and the output register. Uses lqs_pkg; drives lqs_mem.
`timescale 1ns / 1ps

module lqs_ctrl #(
  parameter int DEPTH = lqs_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  lqs_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output lqs_pkg::out_item_t                out_data,
  output logic                              mem_we,
  output logic [$clog2(DEPTH)-1:0]          mem_waddr,
  output logic signed [lqs_pkg::WORD_W-1:0] mem_wdata,
  output logic                              mem_re,
  output logic [$clog2(DEPTH)-1:0]          mem_raddr,
  input  logic signed [lqs_pkg::WORD_W-1:0] mem_rdata
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

  lqs_pkg::fsm_t                     state_r, state_nxt;
  lqs_pkg::op_t                      op_r, op_nxt;
  logic signed [lqs_pkg::WORD_W-1:0] val_r, val_nxt;
  logic [IDX_W-1:0]                  head_r, head_nxt;
  logic [IDX_W-1:0]                  tail_r, tail_nxt;
  logic [IDX_W-1:0]                  ptr_r, ptr_nxt;
  logic                              holds_r, holds_nxt;
  logic                              out_valid_r, out_valid_nxt;
  lqs_pkg::out_item_t                out_data_r, out_data_nxt;

  logic               full_now;
  logic               out_free;
  logic               at_tail;
  logic               match;
  logic               emit;
  lqs_pkg::out_item_t res;

  assign full_now = holds_r && (tail_r == LAST_IDX);
  assign out_free = !out_valid_r || out_ready;
  assign at_tail  = (ptr_r == tail_r);
  assign match    = (mem_rdata == val_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lqs_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = lqs_pkg::S_DECIDE;
        end
      end
      lqs_pkg::S_DECIDE: begin
        if (holds_r && op_r != lqs_pkg::OP_ENQ) begin
          state_nxt = lqs_pkg::S_WALK;
        end else if (out_free) begin
          state_nxt = lqs_pkg::S_IDLE;
        end
      end
      lqs_pkg::S_WALK: begin
        if (out_free) begin
          case (op_r)
            lqs_pkg::OP_TRAV: if (at_tail) state_nxt = lqs_pkg::S_IDLE;
            lqs_pkg::OP_SRCH: if (match || at_tail) state_nxt = lqs_pkg::S_IDLE;
            default:          state_nxt = lqs_pkg::S_IDLE;
          endcase
        end
      end
      default: state_nxt = lqs_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    op_nxt    = op_r;
    val_nxt   = val_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    holds_nxt = holds_r;
    ptr_nxt   = ptr_r;
    mem_we    = 1'b0;
    mem_waddr = tail_r;
    mem_wdata = val_r;
    mem_re    = 1'b0;
    mem_raddr = ptr_r;
    emit      = 1'b0;
    res            = '0;
    res.status     = lqs_pkg::ST_INSERTED;
    res.last       = 1'b1;

    case (state_r)
      lqs_pkg::S_IDLE: begin
        if (in_valid) begin
          op_nxt  = in_data.opcode;
          val_nxt = in_data.data_value;
        end
      end
      lqs_pkg::S_DECIDE: begin
        if (op_r == lqs_pkg::OP_ENQ) begin
          if (out_free) begin
            emit = 1'b1;
            if (full_now) begin
              res.status = lqs_pkg::ST_OVERFLOW;
            end else begin
              if (!holds_r) begin
                head_nxt  = '0;
                tail_nxt  = '0;
                holds_nxt = 1'b1;
              end else begin
                tail_nxt = tail_r + 1'b1;
              end
              mem_we         = 1'b1;
              mem_waddr      = tail_nxt;
              res.status     = lqs_pkg::ST_INSERTED;
              res.word       = val_r;
              res.slot_index = lqs_pkg::SLOT_W'(tail_nxt);
            end
          end
        end else if (!holds_r) begin
          if (out_free) begin
            emit = 1'b1;
            if (op_r == lqs_pkg::OP_DEQ) begin
              res.status = lqs_pkg::ST_UNDERFLOW;
            end else begin
              res.status = lqs_pkg::ST_EMPTY;
              if (op_r == lqs_pkg::OP_SRCH) begin
                res.word = val_r;
              end
            end
          end
        end else begin
          // Start the walk at the head; data shows up in the next cycle.
          mem_re    = 1'b1;
          mem_raddr = head_r;
          ptr_nxt   = head_r;
        end
      end
      lqs_pkg::S_WALK: begin
        if (out_free) begin
          case (op_r)
            lqs_pkg::OP_DEQ: begin
              emit           = 1'b1;
              res.status     = lqs_pkg::ST_REMOVED;
              res.word       = mem_rdata;
              res.slot_index = lqs_pkg::SLOT_W'(ptr_r);
              // Taking the last word returns the queue to its reset state.
              if (head_r >= tail_r) begin
                head_nxt  = '0;
                tail_nxt  = '0;
                holds_nxt = 1'b0;
              end else begin
                head_nxt = head_r + 1'b1;
              end
            end
            lqs_pkg::OP_TRAV: begin
              emit           = 1'b1;
              res.status     = lqs_pkg::ST_ELEMENT;
              res.word       = mem_rdata;
              res.slot_index = lqs_pkg::SLOT_W'(ptr_r);
              res.last       = at_tail;
              if (!at_tail) begin
                ptr_nxt   = ptr_r + 1'b1;
                mem_re    = 1'b1;
                mem_raddr = ptr_nxt;
              end
            end
            lqs_pkg::OP_SRCH: begin
              res.word = val_r;
              if (match) begin
                emit           = 1'b1;
                res.status     = lqs_pkg::ST_ELEMENT;
                res.slot_index = lqs_pkg::SLOT_W'(ptr_r);
              end else if (at_tail) begin
                emit       = 1'b1;
                res.status = lqs_pkg::ST_NOTFOUND;
              end else begin
                ptr_nxt   = ptr_r + 1'b1;
                mem_re    = 1'b1;
                mem_raddr = ptr_nxt;
              end
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
      end
    endcase

    // Flags report the queue as it stands after this transaction.
    res.full_flag  = holds_nxt && (tail_nxt == LAST_IDX);
    res.empty_flag = !holds_nxt;

    out_valid_nxt = emit || (out_valid_r && !out_ready);
    out_data_nxt  = emit ? res : out_data_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lqs_pkg::S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      holds_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      holds_r     <= holds_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    val_r      <= val_nxt;
    ptr_r      <= ptr_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_ready  = (state_r == lqs_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: rtl/linear_queue_with_search.sv
// Linear queue with search, top level. Enqueue, overflow, underflow and empty results
// come from the decide state; dequeue, search and traverse go on to the walk state, as
// the single read port walks one slot per cycle while the output is not stalled.
// A new transaction is taken only once the sequencer is back in its idle state.
// Synchronous active-low reset empties the queue; slot contents are not cleared.
`timescale 1ns / 1ps

module linear_queue_with_search #(
  parameter int DEPTH = lqs_pkg::DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  lqs_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output lqs_pkg::out_item_t out_data
);

  localparam int IDX_W = $clog2(DEPTH);

  logic                              mem_we;
  logic [IDX_W-1:0]                  mem_waddr;
  logic signed [lqs_pkg::WORD_W-1:0] mem_wdata;
  logic                              mem_re;
  logic [IDX_W-1:0]                  mem_raddr;
  logic signed [lqs_pkg::WORD_W-1:0] mem_rdata;

  lqs_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  lqs_mem #(
    .DEPTH(DEPTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // The block is busy in the cycle after taking a transaction.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted on consecutive cycles");

  // The slot store is never written and read in the same cycle.
  a_mem_one_access: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> !mem_re)
    else $error("slot store written and read together");

  // An overflow result always reports a full queue.
  a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == lqs_pkg::ST_OVERFLOW |-> out_data.full_flag)
    else $error("overflow reported on a queue that is not full");

  // Underflow and empty results always report an empty queue.
  a_underflow_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == lqs_pkg::ST_UNDERFLOW ||
                  out_data.status == lqs_pkg::ST_EMPTY) |-> out_data.empty_flag)
    else $error("empty status reported on a queue that holds data");

endmodule
